### hw/rtl/imsc_pkg.sv
// Shared types, constants and the requantize function for the int8 matmul block.
// No dependencies; every other file in hw/rtl imports this package.
package imsc_pkg;

	localparam int DEF_MAX_K = 64;
	localparam int DEF_MAX_N = 16;

	localparam int ACC_W  = 22;
	localparam int PROD_W = 16;

	localparam logic signed [7:0] SAT_MAX = 8'sd127;
	localparam logic signed [7:0] SAT_MIN = -8'sd128;

	// configuration register indexes
	localparam logic [1:0] CFG_K_DEPTH = 2'd0;
	localparam logic [1:0] CFG_N_COLS  = 2'd1;
	localparam logic [1:0] CFG_SHIFT   = 2'd2;

	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_ACT    = 1'b1;

	localparam logic [6:0] RST_K_DEPTH = 7'd64;
	localparam logic [4:0] RST_N_COLS  = 5'd16;
	localparam logic [4:0] RST_SHIFT   = 5'd0;

	typedef struct packed {
		logic              op;
		logic [5:0]        k_index;
		logic [3:0]        col_index;
		logic signed [7:0] value;
		logic              last_row;
	} item_t;

	typedef struct packed {
		logic signed [7:0] out_value;
		logic [3:0]        out_col;
		logic              last;
		logic              matrix_end;
	} result_t;

	// control that rides along an activation through the MAC pipeline
	typedef struct packed {
		logic valid;
		logic clear;
		logic emit;
		logic last_row;
	} mac_ctrl_t;

	// MAC status seen by the top level and the emitter
	typedef struct packed {
		logic pend;
		logic done;
		logic last_row;
	} mac_stat_t;

	function automatic logic signed [7:0] requant(
		input logic signed [ACC_W-1:0] acc,
		input logic [4:0]              sh
	);
		logic signed [ACC_W-1:0] r;
		logic                    fits;
		r    = acc >>> sh;
		fits = (r[ACC_W-1:7] == '0) || (r[ACC_W-1:7] == '1);
		if (fits) begin
			requant = r[7:0];
		end else if (r[ACC_W-1]) begin
			requant = SAT_MIN;
		end else begin
			requant = SAT_MAX;
		end
	endfunction

endpackage

### hw/rtl/imsc_wmem.sv
// Weight store: one wide row per inner-dimension index, one byte lane per column.
// Depends on imsc_pkg for defaults.
module imsc_wmem #(
	parameter int MAX_K = imsc_pkg::DEF_MAX_K,
	parameter int MAX_N = imsc_pkg::DEF_MAX_N,
	parameter int KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1,
	parameter int CW    = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [KW-1:0]        waddr,
	input  logic [CW-1:0]        wcol,
	input  logic [7:0]           wdata,
	input  logic                 re,
	input  logic [KW-1:0]        raddr,
	output logic [MAX_N*8-1:0]   rdata
);
	import imsc_pkg::*;

	logic [MAX_N*8-1:0] mem [MAX_K];
	logic [MAX_N*8-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wcol*8 +: 8] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/imsc_mac.sv
// MAC lanes: one 8x8 multiplier and one 22-bit accumulator per column.
// Takes the registered weight row from imsc_wmem; depends on imsc_pkg.
module imsc_mac #(
	parameter int MAX_N = imsc_pkg::DEF_MAX_N
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  imsc_pkg::mac_ctrl_t                      ctrl,
	input  logic signed [7:0]                        act,
	input  logic [MAX_N*8-1:0]                       wrow,
	input  logic                                     clear_all,
	output logic [MAX_N-1:0][imsc_pkg::ACC_W-1:0]    acc,
	output imsc_pkg::mac_stat_t                      stat
);
	import imsc_pkg::*;

	mac_ctrl_t                        ctrl_s1;
	mac_ctrl_t                        ctrl_s2;
	logic signed [7:0]                act_s1;
	logic [MAX_N-1:0][PROD_W-1:0]     prod_s2;
	logic [MAX_N-1:0][ACC_W-1:0]      acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.valid) begin
			act_s1 <= act;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_N; j++) begin
			if (ctrl_s1.valid) begin
				prod_s2[j] <= PROD_W'(act_s1 * $signed(wrow[j*8 +: 8]));
			end
		end
	end

	// row start and end of emission both zero the accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear_all) begin
			acc_q <= '0;
		end else if (ctrl_s2.valid) begin
			for (int j = 0; j < MAX_N; j++) begin
				acc_q[j] <= (ctrl_s2.clear ? ACC_W'(0) : acc_q[j])
					+ {{(ACC_W-PROD_W){prod_s2[j][PROD_W-1]}}, prod_s2[j]};
			end
		end
	end

	assign acc           = acc_q;
	assign stat.pend     = (ctrl_s1.valid && ctrl_s1.emit) || (ctrl_s2.valid && ctrl_s2.emit);
	assign stat.done     = ctrl_s2.valid && ctrl_s2.emit;
	assign stat.last_row = ctrl_s2.last_row;

endmodule

### hw/rtl/imsc_emit.sv
// Result sequencer: walks the columns, requantizes each accumulator into a
// registered output slot. Depends on imsc_pkg.
module imsc_emit #(
	parameter int MAX_N = imsc_pkg::DEF_MAX_N,
	parameter int CW    = (MAX_N > 1) ? $clog2(MAX_N) : 1,
	parameter int NCW   = $clog2(MAX_N + 1)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  imsc_pkg::mac_stat_t                      stat,
	input  logic [MAX_N-1:0][imsc_pkg::ACC_W-1:0]    acc,
	input  logic [NCW-1:0]                           eff_n,
	input  logic [4:0]                               shift_amount,
	output logic                                     busy,
	output logic                                     clear_all,
	output logic                                     res_valid,
	input  logic                                     res_ready,
	output imsc_pkg::result_t                        res
);
	import imsc_pkg::*;

	logic          busy_q;
	logic [CW-1:0] col_q;
	logic          last_row_q;
	logic          res_valid_q;
	result_t       res_q;
	logic          load;
	logic          is_last;

	assign load    = busy_q && (!res_valid_q || res_ready);
	assign is_last = 32'(col_q) == 32'(eff_n) - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			col_q       <= '0;
			last_row_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (stat.done) begin
				busy_q     <= 1'b1;
				col_q      <= '0;
				last_row_q <= stat.last_row;
			end else if (load) begin
				col_q <= col_q + CW'(1);
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_value  <= requant($signed(acc[col_q]), shift_amount);
			res_q.out_col    <= 4'(col_q);
			res_q.last       <= is_last;
			res_q.matrix_end <= is_last && last_row_q;
		end
	end

	assign busy      = busy_q;
	assign clear_all = load && is_last;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) stat.done |-> !busy_q)
		else $error("row finished while previous row still emitting");
	assert property (@(posedge clk) disable iff (!arst_n)
		clear_all |=> (res_valid_q && res_q.last))
		else $error("accumulators cleared without final result in output slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !load) |=> $stable(col_q))
		else $error("column advanced without a load");

endmodule

### hw/rtl/int8_matmul_shift_clamp.sv
// Int8 matrix multiply with shift-and-clamp requantize; top level.
// Path: a row-final request passes ctrl_s1, ctrl_s2 and the emitter busy flag to the output slot.
// Flow: weights and non-final activations 1 per cycle while item_ready is high; a row's final
// element drops item_ready until its last result loads; results leave 1 per cycle if not stalled.
// Reset: config returns to K=64, N=16, shift 0; accumulators zeroed; weight store
// is not cleared. Uses imsc_pkg, imsc_wmem, imsc_mac, imsc_emit.
module int8_matmul_shift_clamp #(
	parameter int MAX_K = imsc_pkg::DEF_MAX_K,
	parameter int MAX_N = imsc_pkg::DEF_MAX_N
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  imsc_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_ready,
	output imsc_pkg::result_t res
);
	import imsc_pkg::*;

	localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int CW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int KCW = $clog2(MAX_K + 1);
	localparam int NCW = $clog2(MAX_N + 1);

	logic [6:0] k_depth_q;
	logic [4:0] n_cols_q;
	logic [4:0] shift_q;

	logic [KCW-1:0] eff_k;
	logic [NCW-1:0] eff_n;

	logic                        accept;
	logic                        we;
	mac_ctrl_t                   ctrl;
	logic [MAX_N*8-1:0]          wrow;
	logic [MAX_N-1:0][ACC_W-1:0] acc;
	mac_stat_t                   stat;
	logic                        emit_busy;
	logic                        clear_all;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_depth_q <= RST_K_DEPTH;
			n_cols_q  <= RST_N_COLS;
			shift_q   <= RST_SHIFT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_K_DEPTH: k_depth_q <= cfg_data;
				CFG_N_COLS:  n_cols_q  <= cfg_data[4:0];
				CFG_SHIFT:   shift_q   <= cfg_data[4:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		if (k_depth_q == '0) begin
			eff_k = KCW'(1);
		end else if (32'(k_depth_q) > MAX_K) begin
			eff_k = KCW'(MAX_K);
		end else begin
			eff_k = KCW'(k_depth_q);
		end
		if (n_cols_q == '0) begin
			eff_n = NCW'(1);
		end else if (32'(n_cols_q) > MAX_N) begin
			eff_n = NCW'(MAX_N);
		end else begin
			eff_n = NCW'(n_cols_q);
		end
	end

	// hold input while a finished row is on its way out
	assign item_ready = !(stat.pend || emit_busy);
	assign accept     = item_valid && item_ready;

	assign we = accept && (item.op == OP_WEIGHT)
		&& (32'(item.k_index) < MAX_K) && (32'(item.col_index) < MAX_N);

	assign ctrl.valid    = accept && (item.op == OP_ACT) && (32'(item.k_index) < 32'(eff_k));
	assign ctrl.clear    = item.k_index == '0;
	assign ctrl.emit     = 32'(item.k_index) == 32'(eff_k) - 32'd1;
	assign ctrl.last_row = item.last_row;

	imsc_wmem #(.MAX_K(MAX_K), .MAX_N(MAX_N), .KW(KW), .CW(CW)) u_wmem (
		.clk   (clk),
		.we    (we),
		.waddr (KW'(item.k_index)),
		.wcol  (CW'(item.col_index)),
		.wdata (item.value),
		.re    (ctrl.valid),
		.raddr (KW'(item.k_index)),
		.rdata (wrow)
	);

	imsc_mac #(.MAX_N(MAX_N)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.act       (item.value),
		.wrow      (wrow),
		.clear_all (clear_all),
		.acc       (acc),
		.stat      (stat)
	);

	imsc_emit #(.MAX_N(MAX_N), .CW(CW), .NCW(NCW)) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.acc          (acc),
		.eff_n        (eff_n),
		.shift_amount (shift_q),
		.busy         (emit_busy),
		.clear_all    (clear_all),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.valid && ctrl.emit) |=> !item_ready)
		else $error("input not held after row-final request");
	assert property (@(posedge clk) disable iff (!arst_n) emit_busy |-> !item_ready)
		else $error("input open while results are being emitted");
	assert property (@(posedge clk) disable iff (!arst_n) !(we && ctrl.valid))
		else $error("weight write and activation read in one cycle");

endmodule
